FILE: src/vch_pkg.sv
// ============================================================================
// Victim cache hierarchy package
// Shared types and constants for the controller and the datapath.
// ============================================================================
`default_nettype none

package vch_pkg;

    localparam int unsigned TAG_W   = 26;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LEVEL_W = 3;
    localparam int unsigned CNT_N   = 6;

    localparam logic [LEVEL_W-1:0] LVL_L1     = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_VICTIM = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_L2     = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_MEM    = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_WRITE  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_CASCADE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic read_sets;
        logic execute;
        logic cascade;
        logic publish;
    } vch_cmd_t;

    typedef struct packed {
        logic needs_cascade;
    } vch_status_t;

endpackage

`default_nettype wire

FILE: src/vch_ctrl.sv
// ============================================================================
// Victim cache hierarchy controller
// Sequences one transaction through read, lookup, cascade and result stages.
// ============================================================================
`default_nettype none

module vch_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output vch_pkg::vch_cmd_t         cmd,
    input  wire vch_pkg::vch_status_t status
);

    vch_pkg::state_t state_reg;
    vch_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vch_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            vch_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = vch_pkg::ST_READ;
                end
            end
            vch_pkg::ST_READ:
            begin
                cmd.read_sets = 1'b1;
                state_next    = vch_pkg::ST_LOOKUP;
            end
            vch_pkg::ST_LOOKUP:
            begin
                cmd.execute = 1'b1;
                state_next  = status.needs_cascade ? vch_pkg::ST_CASCADE : vch_pkg::ST_DONE;
            end
            vch_pkg::ST_CASCADE:
            begin
                cmd.cascade = 1'b1;
                state_next  = vch_pkg::ST_DONE;
            end
            vch_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = vch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vch_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/vch_datapath.sv
// ============================================================================
// Victim cache hierarchy datapath
// L1, victim store and L2 arrays with lookup, swap, cascade and counters.
// ============================================================================
`default_nettype none

module vch_datapath #(
    parameter int unsigned SPILL_ENTRIES = 4,
    parameter int unsigned SECOND_WAYS   = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire vch_pkg::vch_cmd_t              cmd,
    output vch_pkg::vch_status_t                status,
    input  wire logic                           op_in,
    input  wire logic [31:0]                    addr_in,
    input  wire logic [vch_pkg::WORD_W-1:0]     wval_in,
    input  wire logic [vch_pkg::WORD_W-1:0]     mval_in,
    output logic [vch_pkg::LEVEL_W-1:0]         level_out,
    output logic [vch_pkg::WORD_W-1:0]          rval_out,
    output logic [vch_pkg::CNT_N*32-1:0]        counts_out
);

    localparam int unsigned SE_W  = (SPILL_ENTRIES > 1) ? $clog2(SPILL_ENTRIES) : 1;
    localparam int unsigned SW_W  = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
    localparam int unsigned VT_W  = vch_pkg::IDX_W + vch_pkg::TAG_W;
    localparam int unsigned SETS  = 16;
    localparam int unsigned L2_N  = SETS * (2 ** SW_W);
    localparam int unsigned ROW_W = vch_pkg::TAG_W + vch_pkg::WORD_W;

    // Transaction capture.
    logic                          op_reg;
    logic [vch_pkg::IDX_W-1:0]     idx_reg;
    logic [vch_pkg::TAG_W-1:0]     tag_reg;
    logic [vch_pkg::WORD_W-1:0]    wval_reg;
    logic [vch_pkg::WORD_W-1:0]    mval_reg;

    // L1 and victim store live in flops.
    logic [SETS-1:0]               l1_valid_reg;
    logic [vch_pkg::TAG_W-1:0]     l1_tag_reg   [SETS];
    logic [vch_pkg::WORD_W-1:0]    l1_word_reg  [SETS];
    logic [SPILL_ENTRIES-1:0]      sp_valid_reg;
    logic [VT_W-1:0]               sp_tag_reg   [SPILL_ENTRIES];
    logic [vch_pkg::WORD_W-1:0]    sp_word_reg  [SPILL_ENTRIES];
    logic [SE_W-1:0]               sp_age_reg   [SPILL_ENTRIES];

    // Each L2 set is one memory row holding all its ways; valid and age bits live in flops.
    logic [SECOND_WAYS-1:0][ROW_W-1:0] l2_mem [SETS];
    logic [L2_N-1:0]                   l2_valid_reg;
    logic [SECOND_WAYS-1:0][SW_W-1:0]  l2_age_reg [SETS];
    logic [SECOND_WAYS-1:0][ROW_W-1:0] rd_row_reg;

    logic [31:0]                   cnt_reg [vch_pkg::CNT_N];
    logic [vch_pkg::LEVEL_W-1:0]   level_reg;
    logic [vch_pkg::WORD_W-1:0]    rval_reg;

    // Pending cascade into L2.
    logic [vch_pkg::IDX_W-1:0]     casc_set_reg;
    logic [vch_pkg::TAG_W-1:0]     casc_tag_reg;
    logic [vch_pkg::WORD_W-1:0]    casc_word_reg;
    logic [L2_N-1:0]               l2_valid_next;
    logic [SW_W-1:0]               casc_pick;

    // Lookup.
    logic                          l1_hit;
    logic                          sp_hit;
    logic [SE_W-1:0]               sp_e;
    logic                          l2_hit;
    logic [SW_W-1:0]               l2_w;
    logic [SE_W-1:0]               sp_pick;
    logic [VT_W-1:0]               vtag;

    assign vtag = {idx_reg, tag_reg};

    always_comb
    begin
        l1_hit = l1_valid_reg[idx_reg] && (l1_tag_reg[idx_reg] == tag_reg);
        sp_hit = 1'b0;
        sp_e   = '0;
        for (int i = SPILL_ENTRIES - 1; i >= 0; i--)
        begin
            if (sp_valid_reg[i] && sp_tag_reg[i] == vtag)
            begin
                sp_hit = 1'b1;
                sp_e   = SE_W'(i);
            end
        end
        l2_hit = 1'b0;
        l2_w   = '0;
        for (int i = SECOND_WAYS - 1; i >= 0; i--)
        begin
            if (l2_valid_reg[{idx_reg, SW_W'(i)}]
                && rd_row_reg[i][ROW_W-1:vch_pkg::WORD_W] == tag_reg)
            begin
                l2_hit = 1'b1;
                l2_w   = SW_W'(i);
            end
        end
        sp_pick = '0;
        for (int i = SPILL_ENTRIES - 1; i >= 0; i--)
        begin
            if (sp_age_reg[i] == '0)
            begin
                sp_pick = SE_W'(i);
            end
        end
        for (int i = SPILL_ENTRIES - 1; i >= 0; i--)
        begin
            if (!sp_valid_reg[i])
            begin
                sp_pick = SE_W'(i);
            end
        end
        casc_pick = '0;
        for (int i = SECOND_WAYS - 1; i >= 0; i--)
        begin
            if (l2_age_reg[casc_set_reg][i] == '0)
            begin
                casc_pick = SW_W'(i);
            end
        end
        for (int i = SECOND_WAYS - 1; i >= 0; i--)
        begin
            if (!l2_valid_reg[{casc_set_reg, SW_W'(i)}])
            begin
                casc_pick = SW_W'(i);
            end
        end
    end

    // A read that misses L1 and the victim store with a valid L1 line, while every victim
    // entry is valid, pushes the replaced victim entry down into L2.
    assign status.needs_cascade = !op_reg && !l1_hit && !sp_hit
                                  && l1_valid_reg[idx_reg] && sp_valid_reg[sp_pick];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_in;
            idx_reg  <= addr_in[5:2];
            tag_reg  <= addr_in[31:6];
            wval_reg <= wval_in;
            mval_reg <= mval_in;
        end
        if (cmd.read_sets)
        begin
            rd_row_reg <= l2_mem[idx_reg];
        end
        if (cmd.execute && op_reg && !l1_hit && !sp_hit && l2_hit)
        begin
            l2_mem[idx_reg][l2_w] <= {tag_reg, wval_reg};
        end
        if (cmd.cascade)
        begin
            l2_mem[casc_set_reg][casc_pick] <= {casc_tag_reg, casc_word_reg};
        end
    end

    always_comb
    begin
        l2_valid_next = l2_valid_reg;
        if (cmd.execute && !op_reg && !l1_hit && !sp_hit && l2_hit)
        begin
            l2_valid_next[{idx_reg, l2_w}] = 1'b0;
        end
        if (cmd.cascade)
        begin
            l2_valid_next[{casc_set_reg, casc_pick}] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= '0;
            sp_valid_reg <= '0;
            l2_valid_reg <= '0;
            level_reg    <= vch_pkg::LVL_L1;
            rval_reg     <= '0;
            for (int i = 0; i < SPILL_ENTRIES; i++)
            begin
                sp_age_reg[i] <= SE_W'(i);
            end
            for (int s = 0; s < SETS; s++)
            begin
                for (int w = 0; w < SECOND_WAYS; w++)
                begin
                    l2_age_reg[s][w] <= SW_W'(w);
                end
            end
            for (int k = 0; k < vch_pkg::CNT_N; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            l2_valid_reg <= l2_valid_next;
            if (cmd.cascade)
            begin
                for (int i = 0; i < SECOND_WAYS; i++)
                begin
                    if (SW_W'(i) != casc_pick
                        && l2_age_reg[casc_set_reg][i] > l2_age_reg[casc_set_reg][casc_pick])
                    begin
                        l2_age_reg[casc_set_reg][i] <= l2_age_reg[casc_set_reg][i] - 1'b1;
                    end
                end
                l2_age_reg[casc_set_reg][casc_pick] <= SW_W'(SECOND_WAYS - 1);
            end
            if (cmd.execute)
            begin
                if (op_reg)
                begin
                    level_reg <= vch_pkg::LVL_WRITE;
                    rval_reg  <= '0;
                    if (l1_hit)
                    begin
                        l1_word_reg[idx_reg] <= wval_reg;
                    end
                    else if (sp_hit)
                    begin
                        sp_word_reg[sp_e] <= wval_reg;
                        for (int i = 0; i < SPILL_ENTRIES; i++)
                        begin
                            if (SE_W'(i) != sp_e && sp_age_reg[i] > sp_age_reg[sp_e])
                            begin
                                sp_age_reg[i] <= sp_age_reg[i] - 1'b1;
                            end
                        end
                        sp_age_reg[sp_e] <= SE_W'(SPILL_ENTRIES - 1);
                    end
                    else if (l2_hit)
                    begin
                        for (int i = 0; i < SECOND_WAYS; i++)
                        begin
                            if (SW_W'(i) != l2_w
                                && l2_age_reg[idx_reg][i] > l2_age_reg[idx_reg][l2_w])
                            begin
                                l2_age_reg[idx_reg][i] <= l2_age_reg[idx_reg][i] - 1'b1;
                            end
                        end
                        l2_age_reg[idx_reg][l2_w] <= SW_W'(SECOND_WAYS - 1);
                    end
                end
                else if (l1_hit)
                begin
                    level_reg <= vch_pkg::LVL_L1;
                    rval_reg  <= l1_word_reg[idx_reg];
                    if (cnt_reg[0] != '1)
                    begin
                        cnt_reg[0] <= cnt_reg[0] + 32'd1;
                    end
                end
                else
                begin
                    if (cnt_reg[1] != '1)
                    begin
                        cnt_reg[1] <= cnt_reg[1] + 32'd1;
                    end
                    l1_valid_reg[idx_reg] <= 1'b1;
                    l1_tag_reg[idx_reg]   <= tag_reg;
                    if (sp_hit)
                    begin
                        if (cnt_reg[2] != '1)
                        begin
                            cnt_reg[2] <= cnt_reg[2] + 32'd1;
                        end
                        level_reg            <= vch_pkg::LVL_VICTIM;
                        rval_reg             <= sp_word_reg[sp_e];
                        l1_word_reg[idx_reg] <= sp_word_reg[sp_e];
                        if (l1_valid_reg[idx_reg])
                        begin
                            sp_tag_reg[sp_e]  <= {idx_reg, l1_tag_reg[idx_reg]};
                            sp_word_reg[sp_e] <= l1_word_reg[idx_reg];
                        end
                        else
                        begin
                            sp_valid_reg[sp_e] <= 1'b0;
                        end
                        for (int i = 0; i < SPILL_ENTRIES; i++)
                        begin
                            if (SE_W'(i) != sp_e && sp_age_reg[i] > sp_age_reg[sp_e])
                            begin
                                sp_age_reg[i] <= sp_age_reg[i] - 1'b1;
                            end
                        end
                        sp_age_reg[sp_e] <= SE_W'(SPILL_ENTRIES - 1);
                    end
                    else
                    begin
                        if (cnt_reg[3] != '1)
                        begin
                            cnt_reg[3] <= cnt_reg[3] + 32'd1;
                        end
                        if (l2_hit)
                        begin
                            if (cnt_reg[4] != '1)
                            begin
                                cnt_reg[4] <= cnt_reg[4] + 32'd1;
                            end
                            level_reg            <= vch_pkg::LVL_L2;
                            rval_reg             <= rd_row_reg[l2_w][vch_pkg::WORD_W-1:0];
                            l1_word_reg[idx_reg] <= rd_row_reg[l2_w][vch_pkg::WORD_W-1:0];
                        end
                        else
                        begin
                            if (cnt_reg[5] != '1)
                            begin
                                cnt_reg[5] <= cnt_reg[5] + 32'd1;
                            end
                            level_reg            <= vch_pkg::LVL_MEM;
                            rval_reg             <= mval_reg;
                            l1_word_reg[idx_reg] <= mval_reg;
                        end
                        if (l1_valid_reg[idx_reg])
                        begin
                            if (sp_valid_reg[sp_pick])
                            begin
                                casc_set_reg  <= sp_tag_reg[sp_pick][VT_W-1:vch_pkg::TAG_W];
                                casc_tag_reg  <= sp_tag_reg[sp_pick][vch_pkg::TAG_W-1:0];
                                casc_word_reg <= sp_word_reg[sp_pick];
                            end
                            sp_valid_reg[sp_pick] <= 1'b1;
                            sp_tag_reg[sp_pick]   <= {idx_reg, l1_tag_reg[idx_reg]};
                            sp_word_reg[sp_pick]  <= l1_word_reg[idx_reg];
                            for (int i = 0; i < SPILL_ENTRIES; i++)
                            begin
                                if (SE_W'(i) != sp_pick
                                    && sp_age_reg[i] > sp_age_reg[sp_pick])
                                begin
                                    sp_age_reg[i] <= sp_age_reg[i] - 1'b1;
                                end
                            end
                            sp_age_reg[sp_pick] <= SE_W'(SPILL_ENTRIES - 1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            level_out <= level_reg;
            rval_out  <= rval_reg;
            for (int k = 0; k < vch_pkg::CNT_N; k++)
            begin
                counts_out[k*32 +: 32] <= cnt_reg[k];
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/victim_cache_hierarchy_unit.sv
// ============================================================================
// Victim cache hierarchy unit
// Exclusive L1, victim store and L2 with LRU replacement and read counters.
// ============================================================================
// Channel  Direction  Fields
// s_axis   in         tdata: operation, address, write_value, memory_word
// m_axis   out        tdata: hit_level, read_value, six read counters
//
// A transaction passes through the idle, read, lookup and done states, with a
// cascade state before done that writes the displaced victim line into its L2 set.
// Reset clears all valid bits and counters and presets the ages at once; no clearing pass.
// A result waits in the output register while the next transaction enters.
// The result stage holds while the previous result is still waiting on m_axis.
// ============================================================================
`default_nettype none

module victim_cache_hierarchy_unit #(
    parameter int unsigned SPILL_ENTRIES = 4,
    parameter int unsigned SECOND_WAYS   = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[0], address[32:1], write_value[64:33], memory_word[96:65]
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit_level[2:0], read_value[34:3], counters 32 bits each from bit 35
    output logic [231:0]      m_axis_tdata
);

    vch_pkg::vch_cmd_t    cmd;
    vch_pkg::vch_status_t status;
    logic [2:0]           level;
    logic [31:0]          rval;
    logic [191:0]         counts;

    vch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    vch_datapath #(
        .SPILL_ENTRIES (SPILL_ENTRIES),
        .SECOND_WAYS   (SECOND_WAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op_in      (s_axis_tdata[0]),
        .addr_in    (s_axis_tdata[32:1]),
        .wval_in    (s_axis_tdata[64:33]),
        .mval_in    (s_axis_tdata[96:65]),
        .level_out  (level),
        .rval_out   (rval),
        .counts_out (counts)
    );

    assign m_axis_tdata = {5'd0, counts, rval, level};

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.read_sets, cmd.execute, cmd.cascade, cmd.publish}))
        else $error("more than one datapath command");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_sets |-> !s_axis_tready)
        else $error("input ready while busy");
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> m_axis_tvalid)
        else $error("result not presented");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ============================================================================
// Victim cache hierarchy testbench
// Drives reads and writes into the exclusive L1 / victim / L2 hierarchy over
// the input stream, predicts every result with a behavioral copy of the three
// levels and the read counters, and checks each output transaction in order.
// ============================================================================
`default_nettype none

class vch_scoreboard;

    typedef struct packed {
        logic [31:0] cnt5;
        logic [31:0] cnt4;
        logic [31:0] cnt3;
        logic [31:0] cnt2;
        logic [31:0] cnt1;
        logic [31:0] cnt0;
        logic [31:0] rval;
        logic [2:0]  level;
    } outcome_t;

    bit          l1_v[16];
    bit [25:0]   l1_t[16];
    bit [31:0]   l1_w[16];
    bit          vs_v[4];
    bit [29:0]   vs_t[4];
    bit [31:0]   vs_w[4];
    int          vs_a[4];
    bit          l2_v[16][8];
    bit [25:0]   l2_t[16][8];
    bit [31:0]   l2_w[16][8];
    int          l2_a[16][8];
    bit [31:0]   cnt[6];
    outcome_t    pending[$];
    int          errors;
    int          checked;
    int          level_seen[5];

    function new();
        for (int i = 0; i < 16; i++)
        begin
            l1_v[i] = 0;
            for (int w = 0; w < 8; w++)
            begin
                l2_v[i][w] = 0;
                l2_a[i][w] = w;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            vs_v[i] = 0;
            vs_a[i] = i;
        end
        for (int k = 0; k < 6; k++)
            cnt[k] = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void bump(int k);
        if (cnt[k] != 32'hFFFF_FFFF)
            cnt[k]++;
    endfunction

    function void age_vs(int e);
        int old;
        old = vs_a[e];
        for (int i = 0; i < 4; i++)
            if (i != e && vs_a[i] > old)
                vs_a[i]--;
        vs_a[e] = 3;
    endfunction

    function void age_l2(int s, int e);
        int old;
        old = l2_a[s][e];
        for (int i = 0; i < 8; i++)
            if (i != e && l2_a[s][i] > old)
                l2_a[s][i]--;
        l2_a[s][e] = 7;
    endfunction

    function int pick_vs();
        for (int i = 0; i < 4; i++)
            if (!vs_v[i])
                return i;
        for (int i = 0; i < 4; i++)
            if (vs_a[i] == 0)
                return i;
        return 0;
    endfunction

    function int pick_l2(int s);
        for (int i = 0; i < 8; i++)
            if (!l2_v[s][i])
                return i;
        for (int i = 0; i < 8; i++)
            if (l2_a[s][i] == 0)
                return i;
        return 0;
    endfunction

    function void spill(bit [29:0] vt, bit [31:0] word);
        int e;
        int s;
        int w;
        e = pick_vs();
        if (vs_v[e])
        begin
            s = vs_t[e][29:26];
            w = pick_l2(s);
            l2_v[s][w] = 1;
            l2_t[s][w] = vs_t[e][25:0];
            l2_w[s][w] = vs_w[e];
            age_l2(s, w);
        end
        vs_v[e] = 1;
        vs_t[e] = vt;
        vs_w[e] = word;
        age_vs(e);
    endfunction

    function void note_request(bit op, bit [31:0] addr, bit [31:0] wval, bit [31:0] mval);
        outcome_t o;
        int idx;
        bit [25:0] tg;
        bit [29:0] vt;
        int e;
        int w;
        bit hit1;
        idx = addr[5:2];
        tg = addr[31:6];
        vt = {addr[5:2], tg};
        e = -1;
        w = -1;
        o.level = vch_pkg::LVL_WRITE;
        o.rval = 0;
        for (int i = 0; i < 4; i++)
            if (e < 0 && vs_v[i] && vs_t[i] == vt)
                e = i;
        for (int i = 0; i < 8; i++)
            if (w < 0 && l2_v[idx][i] && l2_t[idx][i] == tg)
                w = i;
        hit1 = l1_v[idx] && l1_t[idx] == tg;
        if (op)
        begin
            if (hit1)
                l1_w[idx] = wval;
            else if (e >= 0)
            begin
                age_vs(e);
                vs_w[e] = wval;
            end
            else if (w >= 0)
            begin
                age_l2(idx, w);
                l2_w[idx][w] = wval;
            end
        end
        else if (hit1)
        begin
            bump(0);
            o.level = vch_pkg::LVL_L1;
            o.rval = l1_w[idx];
        end
        else
        begin
            bump(1);
            if (e >= 0)
            begin
                bump(2);
                o.level = vch_pkg::LVL_VICTIM;
                o.rval = vs_w[e];
                if (l1_v[idx])
                begin
                    vs_t[e] = {addr[5:2], l1_t[idx]};
                    vs_w[e] = l1_w[idx];
                end
                else
                    vs_v[e] = 0;
                age_vs(e);
            end
            else
            begin
                bump(3);
                if (w >= 0)
                begin
                    bump(4);
                    o.level = vch_pkg::LVL_L2;
                    o.rval = l2_w[idx][w];
                    l2_v[idx][w] = 0;
                end
                else
                begin
                    bump(5);
                    o.level = vch_pkg::LVL_MEM;
                    o.rval = mval;
                end
                if (l1_v[idx])
                    spill({addr[5:2], l1_t[idx]}, l1_w[idx]);
            end
            l1_v[idx] = 1;
            l1_t[idx] = tg;
            l1_w[idx] = o.rval;
        end
        o.cnt0 = cnt[0];
        o.cnt1 = cnt[1];
        o.cnt2 = cnt[2];
        o.cnt3 = cnt[3];
        o.cnt4 = cnt[4];
        o.cnt5 = cnt[5];
        pending.push_back(o);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %0d: %s got %h expected %h", checked, what, got, want);
    endfunction

    function void check_result(logic [231:0] data);
        outcome_t g;
        outcome_t x;
        g = data[226:0];
        if (pending.size() == 0)
        begin
            errors++;
            $display("unexpected output transaction %h", data);
            return;
        end
        x = pending.pop_front();
        if (g.level != x.level) report("hit_level", g.level, x.level);
        if (g.rval != x.rval) report("read_value", g.rval, x.rval);
        if (g.cnt0 != x.cnt0) report("l1_hit_count", g.cnt0, x.cnt0);
        if (g.cnt1 != x.cnt1) report("l1_miss_count", g.cnt1, x.cnt1);
        if (g.cnt2 != x.cnt2) report("victim_hit_count", g.cnt2, x.cnt2);
        if (g.cnt3 != x.cnt3) report("victim_miss_count", g.cnt3, x.cnt3);
        if (g.cnt4 != x.cnt4) report("l2_hit_count", g.cnt4, x.cnt4);
        if (g.cnt5 != x.cnt5) report("l2_miss_count", g.cnt5, x.cnt5);
        if (x.level <= 4)
            level_seen[x.level]++;
        checked++;
    endfunction

endclass

module tb_top;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [103:0]   s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [231:0]   m_axis_tdata;

    vch_scoreboard  sb;
    int             send_idle_pct;
    int             stall_pct;
    bit             hold_off;
    bit             timed_out;
    int             quiet_cycles;
    int             sent;
    bit [31:0]      tag_pool[8];

    victim_cache_hierarchy_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[0], s_axis_tdata[32:1],
                                s_axis_tdata[64:33], s_axis_tdata[96:65]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= 5000 && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("** victim_cache_hierarchy_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_access(bit op, bit [31:0] addr, bit [31:0] wval, bit [31:0] mval);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'd0, mval, wval, addr, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic random_access();
        bit [31:0] addr;
        bit        op;
        if ($urandom_range(9) < 8)
            addr = {tag_pool[$urandom_range(7)][31:6], 2'b00, 2'($urandom_range(3)), 2'b00};
        else
            addr = $urandom;
        op = $urandom_range(3) == 0;
        send_access(op, addr, $urandom, $urandom);
    endtask

    task automatic run_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) random_access();
    endtask

    initial
    begin
        sb = new();
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        hold_off = 0;
        timed_out = 0;
        quiet_cycles = 0;
        sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 8; i++)
            tag_pool[i] = $urandom & 32'hFFFF_FFC0;
        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFC0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Full miss, L1 hit, write hit in L1, extremes of the data fields.
        send_access(0, 32'h0000_0000, 32'h0, 32'h8000_0000);
        send_access(0, 32'h0000_0003, 32'h0, 32'h0);
        send_access(1, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0);
        send_access(0, 32'h0000_0000, 32'h0, 32'h0);
        send_access(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        // Conflicts in set 0 fill the victim store and then push lines to L2.
        for (int k = 1; k <= 6; k++)
            send_access(0, k << 6, 32'h0, 32'h1000 + k);
        // Victim hit with a valid L1, write into the victim store and into L2.
        send_access(0, 32'h0000_0140, 32'h0, 32'h0);
        send_access(1, 32'h0000_0100, 32'hA5A5_A5A5, 32'h0);
        send_access(1, 32'h0000_0040, 32'h5A5A_5A5A, 32'h0);
        send_access(0, 32'h0000_0040, 32'h0, 32'h0);
        send_access(0, 32'h0000_0000, 32'h0, 32'h0);
        // Victim hit with a valid L1 line in its set, at the top of the address range.
        send_access(0, 32'hFFFF_FFFC, 32'h0, 32'hFFFF_FFFF);
        send_access(0, 32'hFFFF_FFBC, 32'h0, 32'h1);
        send_access(0, 32'hFFFF_FFFC, 32'h0, 32'h2);

        run_phase(0, 0, 150);
        run_phase(51, 0, 150);
        run_phase(0, 51, 150);
        run_phase(33, 33, 150);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            run_phase(0, 0, 100);
        join
        s_axis_tvalid <= 0;
        stall_pct = 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d results from %0d accesses: L1 %0d, victim %0d, L2 %0d,",
                 sb.checked, sent, sb.level_seen[0], sb.level_seen[1], sb.level_seen[2]);
        $display("memory %0d, writes %0d, under idle and stall phases and a long hold-off.",
                 sb.level_seen[3], sb.level_seen[4]);
        if (sb.errors == 0)
            $display("** victim_cache_hierarchy_unit: PASSED **");
        else
            $display("** victim_cache_hierarchy_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
